// ===== hw/rtl/keyword_token_counter_top_assert.svh =====
// Assertion macros used by the keyword token counter RTL.
`ifndef KEYWORD_TOKEN_COUNTER_TOP_ASSERT_SVH
`define KEYWORD_TOKEN_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define KTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define KTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/kwtc_pkg.sv =====
// Package of the keyword token counter: sizes, codes and helper functions.
package kwtc_pkg;

	localparam int NUM_KEYWORDS = 8;
	localparam int KEY_CHARS    = 7;
	localparam int COUNT_BITS   = 32;

	localparam int KW_SLOTS  = 8;
	localparam int KW_W      = 64;
	localparam int CHAR_W    = 8;
	localparam int TOKLEN_W  = 4;
	localparam int MASK_W    = 8;
	localparam int SEL_W     = 3;
	localparam int OUT_CNT_W = 32;
	localparam int CFG_IDX_W = 4;

	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_PERIOD  = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef logic [KW_W-1:0]       kw_word_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	function automatic logic is_delim(input logic [CHAR_W-1:0] c);
		return c inside {CH_SPACE, CH_COMMA, CH_PERIOD, CH_NEWLINE};
	endfunction

	// Clamp a counter to the 32-bit result field.
	function automatic logic [OUT_CNT_W-1:0] sat_out(input count_t c);
		count_t upper;
		upper = c >> OUT_CNT_W;
		if (upper != '0) begin
			return '1;
		end
		return OUT_CNT_W'(c);
	endfunction

endpackage

// ===== hw/rtl/kwtc_if.sv =====
// Handshake channels of the keyword token counter: text in, result out, config write.
interface kwtc_in_if;
	import kwtc_pkg::*;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [CHAR_W-1:0] byte_value;
	logic              text_end;
	logic [SEL_W-1:0]  keyword_select;
	modport source (output valid, mode, byte_value, text_end, keyword_select, input ready);
	modport sink   (input valid, mode, byte_value, text_end, keyword_select, output ready);
endinterface

interface kwtc_out_if;
	import kwtc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [MASK_W-1:0]    matched_mask;
	logic [OUT_CNT_W-1:0] count_value;
	modport source (output valid, matched_mask, count_value, input ready);
	modport sink   (input valid, matched_mask, count_value, output ready);
endinterface

interface kwtc_cfg_if;
	import kwtc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] addr;
	logic [KW_W-1:0]      data;
	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/keyword_token_counter_top.sv =====
// Keyword token counter: splits a byte stream into tokens and counts keyword hits.
//
// The block reads text one byte per word on the item channel, splits it into
// tokens at space, comma, period and newline, and when a token closes (on a
// delimiter, or after a byte flagged text_end) compares it with up to eight
// keywords held in configuration registers. Each keyword register packs its
// characters in bytes 0 to 6 and its length in byte 7; a length of zero, or
// one above seven, disables it. Every matching keyword's counter goes up by
// one and saturates at all ones, and the result word reports the matches in
// matched_mask. A read-mode word (mode 1) leaves the token in progress alone
// and returns the count of keyword_select in count_value. Every input word
// gives exactly one result word. The datapath is two registers deep: a word
// is taken into an input stage, compared against all keywords in parallel
// while the token state and counters update, and placed in an output
// register. One word is accepted every clock cycle as long as the result
// side keeps taking words; a result moves into the output register as its
// word leaves the input stage, and a stalled output register holds back the
// input stage and then the item channel. Keyword registers are written over
// the cfg channel, which is always ready; an address above seven is ignored.
// Write them only while no word is in flight. Reset clears the keywords,
// counters and token.
module keyword_token_counter_top (
	input  logic            clk,
	input  logic            arst_n,
	kwtc_in_if.sink         item,
	kwtc_out_if.source      result,
	kwtc_cfg_if.sink        cfg
);
	import kwtc_pkg::*;

	// Keyword registers and running state.
	kw_word_t              kw_q [KW_SLOTS];
	count_t                count_q [NUM_KEYWORDS];
	logic [TOKLEN_W-1:0]   tok_len_q;
	logic [MASK_W-1:0]     cand_q;

	// Input stage.
	logic                  valid_s1;
	logic                  mode_s1;
	logic [CHAR_W-1:0]     byte_s1;
	logic                  tend_s1;
	logic [SEL_W-1:0]      sel_s1;

	// Output stage.
	logic                  valid_s2;
	logic [MASK_W-1:0]     mask_s2;
	logic [OUT_CNT_W-1:0]  cnt_s2;

	logic                  advance;
	logic                  text_fire;
	logic                  delim;
	logic                  close_tok;
	logic [TOKLEN_W-1:0]   len_add;
	logic [MASK_W-1:0]     cand_add;
	logic [TOKLEN_W-1:0]   close_len;
	logic [MASK_W-1:0]     close_cand;
	logic [MASK_W-1:0]     hit;
	logic [OUT_CNT_W-1:0]  cnt_read;
	logic [CHAR_W-1:0]     kw_len [KW_SLOTS];
	logic [CHAR_W-1:0]     kw_char [KW_SLOTS];

	// The output register moves whenever it is empty or being taken; the input
	// stage follows it, so a word can enter in every cycle while the output register moves.
	assign advance   = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;
	assign text_fire  = valid_s1 && advance && (mode_s1 == MODE_TEXT);

	always_comb begin
		delim    = is_delim(byte_s1);
		len_add  = (tok_len_q == '1) ? tok_len_q : tok_len_q + 1'b1;
		cand_add = cand_q;
		for (int i = 0; i < KW_SLOTS; i++) begin
			kw_len[i]  = kw_q[i][KW_W-1 -: CHAR_W];
			kw_char[i] = kw_q[i][{tok_len_q[2:0], 3'b000} +: CHAR_W];
			if (tok_len_q >= TOKLEN_W'(KEY_CHARS) || kw_char[i] != byte_s1) begin
				cand_add[i] = 1'b0;
			end
		end
		// A delimiter closes the token as it stands; text_end closes it after
		// this byte has been added.
		close_tok  = delim || tend_s1;
		close_len  = delim ? tok_len_q : len_add;
		close_cand = delim ? cand_q : cand_add;
		hit = '0;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			hit[i] = close_tok && (close_len != '0) && close_cand[i] &&
				(kw_len[i] != '0) && (kw_len[i] <= CHAR_W'(KEY_CHARS)) &&
				(kw_len[i] == CHAR_W'(close_len));
		end
		cnt_read = '0;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			if (sel_s1 == SEL_W'(i)) begin
				cnt_read = sat_out(count_q[i]);
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KW_SLOTS; i++) begin
				kw_q[i] <= '0;
			end
		end else if (cfg.valid && cfg.ready) begin
			for (int i = 0; i < KW_SLOTS; i++) begin
				if (cfg.addr == CFG_IDX_W'(i)) begin
					kw_q[i] <= cfg.data;
				end
			end
		end
	end

	// Token state and counters update as a text word leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_len_q <= '0;
			cand_q    <= '1;
			for (int i = 0; i < NUM_KEYWORDS; i++) begin
				count_q[i] <= '0;
			end
		end else if (text_fire) begin
			if (close_tok) begin
				tok_len_q <= '0;
				cand_q    <= '1;
			end else begin
				tok_len_q <= len_add;
				cand_q    <= cand_add;
			end
			for (int i = 0; i < NUM_KEYWORDS; i++) begin
				if (hit[i] && count_q[i] != '1) begin
					count_q[i] <= count_q[i] + 1'b1;
				end
			end
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_s1 <= item.mode;
			byte_s1 <= item.byte_value;
			tend_s1 <= item.text_end;
			sel_s1  <= item.keyword_select;
		end
		if (valid_s1 && advance) begin
			if (mode_s1 == MODE_READ) begin
				mask_s2 <= '0;
				cnt_s2  <= cnt_read;
			end else begin
				mask_s2 <= hit;
				cnt_s2  <= '0;
			end
		end
	end

	assign result.valid        = valid_s2;
	assign result.matched_mask = mask_s2;
	assign result.count_value  = cnt_s2;

`include "keyword_token_counter_top_assert.svh"

	`KTC_ASSERT_NEXT(a_read_no_mask, valid_s1 && advance && mode_s1 == MODE_READ,
		valid_s2 && mask_s2 == '0, "read word produced a match mask")
	`KTC_ASSERT_NEXT(a_text_no_count, text_fire,
		valid_s2 && cnt_s2 == '0, "text word produced a count")
	`KTC_ASSERT_NEXT(a_close_clears, text_fire && close_tok,
		tok_len_q == '0 && cand_q == '1, "token state not cleared after close")
	`KTC_ASSERT_NEXT(a_empty_no_hit, text_fire && delim && tok_len_q == '0,
		mask_s2 == '0, "empty token reported a match")
	`KTC_ASSERT_NOW(a_hit_needs_close, hit != '0,
		close_tok && close_len != '0, "match without a closing token")

endmodule

// ===== bench/keyword_token_counter_top_tb.sv =====
// Self-checking testbench for the keyword token counter: directed and random text against a predictor.
module keyword_token_counter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kwtc_pkg::*;

	// Register index of the first keyword and the highest index on the cfg channel.
	// The highest index lies past the keywords, so a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_KW0 = '0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_TOP = '1;

	// A result passes the input stage and the output register before it can be taken; the drain wait covers that.
	localparam int DRAIN_CYCLES = 4;

	// The longest stretch without any handshake in a correct run is a sender gap
	// plus a receiver stall plus the pipeline.
	localparam int QUIET_LIMIT = 1000;

	typedef logic [CHAR_W-1:0] char_q_t[$];

	typedef struct packed {
		logic [MASK_W-1:0]    mask;
		logic [OUT_CNT_W-1:0] count;
	} tally_t;

	// Tracks the token in progress and the keyword counters, and holds the
	// result words that are still owed by the block, oldest first.
	class tally_board;
		kw_word_t            keywords[KW_SLOTS];
		count_t              hits[KW_SLOTS];
		logic [TOKLEN_W-1:0] tok_len;
		logic [MASK_W-1:0]   alive;
		tally_t              awaited_q[$];
		int                  mismatches;

		function new();
			foreach (keywords[i]) begin
				keywords[i] = '0;
				hits[i] = '0;
			end
			tok_len = '0;
			alive = '1;
			mismatches = 0;
		endfunction

		function void load_keyword(logic [CFG_IDX_W-1:0] idx, kw_word_t value);
			if (idx < KW_SLOTS) begin
				keywords[idx] = value;
			end
		endfunction

		function bit is_separator(logic [CHAR_W-1:0] c);
			case (c)
				CH_SPACE, CH_COMMA, CH_PERIOD, CH_NEWLINE: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		// Drop every keyword that disagrees with the token at this position.
		// Past the last keyword character nothing can agree any more.
		function void extend_token(logic [CHAR_W-1:0] c);
			for (int i = 0; i < KW_SLOTS; i++) begin
				if (tok_len >= KEY_CHARS) begin
					alive[i] = 1'b0;
				end else if (keywords[i][CHAR_W*tok_len +: CHAR_W] != c) begin
					alive[i] = 1'b0;
				end
			end
			if (tok_len != '1) begin
				tok_len++;
			end
		endfunction

		// Count every enabled keyword that survived and has the token's length.
		function logic [MASK_W-1:0] close_token();
			logic [MASK_W-1:0] hit;
			logic [CHAR_W-1:0] len;
			hit = '0;
			if (tok_len != 0) begin
				for (int i = 0; i < NUM_KEYWORDS; i++) begin
					len = keywords[i][KW_W-1 -: CHAR_W];
					if (alive[i] && len != 0 && len <= KEY_CHARS && len == tok_len) begin
						hit[i] = 1'b1;
						if (hits[i] != '1) begin
							hits[i]++;
						end
					end
				end
			end
			tok_len = '0;
			alive = '1;
			return hit;
		endfunction

		function void note_word(logic md, logic [CHAR_W-1:0] c, logic tend,
				logic [SEL_W-1:0] sel);
			tally_t t;
			longint unsigned wide;
			t = '0;
			if (md == MODE_READ) begin
				if (sel < NUM_KEYWORDS) begin
					wide = hits[sel];
					t.count = (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_CNT_W-1:0];
				end
			end else if (is_separator(c)) begin
				t.mask = close_token();
			end else begin
				extend_token(c);
				if (tend) begin
					t.mask = close_token();
				end
			end
			awaited_q.push_back(t);
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_result(logic [MASK_W-1:0] mask, logic [OUT_CNT_W-1:0] count);
			tally_t t;
			if (awaited_q.size() == 0) begin
				report($sformatf("result word with none awaited: mask %h count %0d",
					mask, count));
			end else begin
				t = awaited_q.pop_front();
				if (mask !== t.mask) begin
					report($sformatf("matched_mask %h, awaited %h", mask, t.mask));
				end
				if (count !== t.count) begin
					report($sformatf("count_value %0d, awaited %0d", count, t.count));
				end
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	kwtc_in_if  item_ch();
	kwtc_out_if res_ch();
	kwtc_cfg_if cfg_ch();

	keyword_token_counter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	tally_board board = new();

	// Keywords currently loaded, used to shape text that can actually match.
	kw_word_t live_kw[KW_SLOTS];

	logic [CHAR_W-1:0] separators[4] = '{CH_SPACE, CH_COMMA, CH_PERIOD, CH_NEWLINE};

	// Per-phase odds, in percent per word for the sender and per cycle for the
	// receiver. The last phase runs without any idling.
	int gap_plan[6]   = '{8, 4, 0, 12, 15, 0};
	int stall_plan[6] = '{6, 10, 15, 0, 4, 0};

	int          gap_pct;
	int          stall_pct;
	int unsigned words_sent;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// All checking happens here, at the rising edge, on values settled since the
	// falling edge. Results are checked before the new word is noted; a result
	// never belongs to a word taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				board.check_result(res_ch.matched_mask, res_ch.count_value);
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				board.load_keyword(cfg_ch.addr, cfg_ch.data);
			end
			if (item_ch.valid && item_ch.ready) begin
				board.note_word(item_ch.mode, item_ch.byte_value, item_ch.text_end,
					item_ch.keyword_select);
			end
		end
	end

	// Watchdog: a run that stops moving words on every channel has hung.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: ready drops for random bursts, with the odds set per phase.
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				res_ch.ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			res_ch.ready = 1'b1;
		end
	end

	function automatic kw_word_t spell(string s, int unsigned n);
		kw_word_t k;
		k = '0;
		for (int j = 0; j < s.len() && j < KEY_CHARS; j++) begin
			k[CHAR_W*j +: CHAR_W] = s[j];
		end
		k[KW_W-1 -: CHAR_W] = CHAR_W'(n);
		return k;
	endfunction

	function automatic char_q_t to_chars(string s);
		char_q_t q;
		for (int j = 0; j < s.len(); j++) begin
			q.push_back(s[j]);
		end
		return q;
	endfunction

	// Mostly a small alphabet so that random text collides with keywords, with
	// the byte extremes and anything at all mixed in.
	function automatic logic [CHAR_W-1:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return CHAR_W'(8'h61 + $urandom_range(0, 2));
		end
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'hFF;
				2: return 8'h7F;
				default: return 8'h80;
			endcase
		end
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// A keyword is sometimes disabled by a zero length or by one above the limit.
	function automatic kw_word_t random_keyword();
		kw_word_t k;
		for (int j = 0; j < KEY_CHARS; j++) begin
			k[CHAR_W*j +: CHAR_W] = pick_char();
		end
		case ($urandom_range(0, 9))
			0: k[KW_W-1 -: CHAR_W] = '0;
			1: k[KW_W-1 -: CHAR_W] = CHAR_W'($urandom_range(KEY_CHARS + 1, 255));
			default: k[KW_W-1 -: CHAR_W] = CHAR_W'($urandom_range(1, KEY_CHARS));
		endcase
		return k;
	endfunction

	// A token that is usually a loaded keyword, at times off by one character,
	// one too many or one too few; otherwise a short random word.
	function automatic char_q_t plausible_token();
		char_q_t q;
		int unsigned slot;
		int unsigned len;
		int unsigned n;
		if ($urandom_range(0, 99) < 60) begin
			slot = $urandom_range(0, KW_SLOTS - 1);
			len = live_kw[slot][KW_W-1 -: CHAR_W];
			if (len == 0) begin
				n = $urandom_range(1, 3);
			end else if (len > KEY_CHARS) begin
				n = $urandom_range(KEY_CHARS, KEY_CHARS + 1);
			end else begin
				n = len;
			end
			for (int j = 0; j < n; j++) begin
				q.push_back(j < KEY_CHARS ? live_kw[slot][CHAR_W*j +: CHAR_W] : pick_char());
			end
			case ($urandom_range(0, 9))
				0: q[$urandom_range(0, q.size() - 1)] = pick_char();
				1: q.push_back(pick_char());
				2: if (q.size() > 1) void'(q.pop_back());
				default: ;
			endcase
		end else begin
			repeat ($urandom_range(1, 8)) q.push_back(pick_char());
		end
		return q;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is
	// taken, with valid still high so the next word can follow without a gap.
	task automatic send_word(logic md, logic [CHAR_W-1:0] c, logic tend,
			logic [SEL_W-1:0] sel);
		int gap;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 18);
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.mode = md;
		item_ch.byte_value = c;
		item_ch.text_end = tend;
		item_ch.keyword_select = sel;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_token(char_q_t chars, bit by_end);
		foreach (chars[j]) begin
			send_word(MODE_TEXT, chars[j], by_end && (j == chars.size() - 1), '0);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] addr, kw_word_t data);
		item_ch.valid = 1'b0;
		cfg_ch.valid = 1'b1;
		cfg_ch.addr = addr;
		cfg_ch.data = data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic load_keywords();
		for (int i = 0; i < KW_SLOTS; i++) begin
			write_reg(CFG_ADDR_KW0 + CFG_IDX_W'(i), live_kw[i]);
		end
		write_reg(CFG_IDX_W'($urandom_range(CFG_ADDR_KW0 + KW_SLOTS, CFG_ADDR_TOP)),
			{$urandom, $urandom});
	endtask

	// Hold the sender until every owed result has come back, then let the
	// pipeline drain.
	task automatic settle();
		item_ch.valid = 1'b0;
		while (board.awaited_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Random text: mostly tokens shaped after the loaded keywords, closed by a
	// delimiter or by the end flag, with reads, noise bytes and long tokens.
	task automatic run_text_phase(int unsigned quota);
		int unsigned stop_at;
		int unsigned r;
		bit by_end;
		char_q_t chars;
		stop_at = words_sent + quota;
		while (words_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// The byte and end flag of a read must be ignored by the block.
				send_word(MODE_READ, CHAR_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), SEL_W'($urandom_range(0, 7)));
			end else if (r < 18) begin
				send_word(MODE_TEXT, CHAR_W'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0, SEL_W'($urandom_range(0, 7)));
			end else begin
				chars.delete();
				if (r < 23) begin
					// Long enough to pass the last keyword character, and at times to run the token length into its ceiling.
					repeat ($urandom_range(KEY_CHARS + 1, 20)) chars.push_back(pick_char());
				end else begin
					chars = plausible_token();
				end
				by_end = ($urandom_range(0, 3) == 0);
				send_token(chars, by_end);
				if (!by_end || $urandom_range(0, 4) == 0) begin
					send_word(MODE_TEXT, separators[$urandom_range(0, 3)],
						$urandom_range(0, 3) == 0, '0);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_TEXT;
		item_ch.byte_value = '0;
		item_ch.text_end = 1'b0;
		item_ch.keyword_select = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = CFG_ADDR_KW0;
		cfg_ch.data = '0;
		gap_pct = 5;
		stall_pct = 5;
		words_sent = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed keywords: a duplicate pair, the longest keyword, one too long,
		// one with zero length, one made of the NUL and top bytes, and all ones.
		live_kw[0] = spell("the", 3);
		live_kw[1] = spell("a", 1);
		live_kw[2] = spell("keyword", KEY_CHARS);
		live_kw[3] = spell("the", 3);
		live_kw[4] = spell("abcdefg", KEY_CHARS + 1);
		live_kw[5] = spell("the", 0);
		live_kw[6] = {8'd2, 40'h0, 8'hFF, 8'h00};
		live_kw[7] = '1;
		load_keywords();
		// Would make "x" a keyword if the block took the out-of-range index.
		write_reg(CFG_ADDR_TOP, spell("x", 1));

		// A read in the middle of a token must leave the token alone.
		send_token(to_chars("t"), 1'b0);
		send_word(MODE_READ, 8'h61, 1'b1, 3'd0);
		send_token(to_chars("he"), 1'b0);
		send_word(MODE_TEXT, CH_SPACE, 1'b0, '0);
		send_token(to_chars("a"), 1'b1);
		// End flag on an empty token counts nothing.
		send_word(MODE_TEXT, CH_COMMA, 1'b1, '0);
		send_token(to_chars("x"), 1'b1);
		// NUL and 0xFF are ordinary token characters.
		send_word(MODE_TEXT, 8'h00, 1'b0, '0);
		send_word(MODE_TEXT, 8'hFF, 1'b0, '0);
		send_word(MODE_TEXT, CH_NEWLINE, 1'b0, '0);
		// A delimiter that also carries the end flag closes the token once.
		send_token(to_chars("keyword"), 1'b0);
		send_word(MODE_TEXT, CH_PERIOD, 1'b1, '0);
		send_word(MODE_READ, 8'h00, 1'b0, 3'd0);
		send_word(MODE_READ, 8'hFF, 1'b0, 3'd2);
		send_word(MODE_READ, 8'h00, 1'b1, 3'd6);
		send_word(MODE_READ, 8'hFF, 1'b1, 3'd7);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				1: begin
					// Extremes of the register contents and of the length byte.
					live_kw[0] = '0;
					live_kw[1] = '1;
					live_kw[2] = {8'd7, {7{8'hFF}}};
					live_kw[3] = {8'd1, 56'h0};
					live_kw[4] = spell("aaaaaaa", KEY_CHARS + 1);
					live_kw[5] = spell("aaaaaaa", KEY_CHARS);
					live_kw[6] = spell("a", 1);
					live_kw[7] = live_kw[6];
				end
				3: begin
					// Every keyword switched off.
					foreach (live_kw[i]) live_kw[i] = '0;
				end
				default: begin
					foreach (live_kw[i]) begin
						live_kw[i] = (i > 0 && $urandom_range(0, 5) == 0) ? live_kw[i-1]
							: random_keyword();
					end
				end
			endcase
			load_keywords();
			gap_pct = gap_plan[ph];
			stall_pct = stall_plan[ph];
			if (ph == 2) begin
				run_text_phase(95);
				// The sender waits here for every owed result before going on.
				settle();
				run_text_phase(95);
			end else begin
				run_text_phase(ph == 3 ? 120 : 190);
			end
		end

		settle();
		if (board.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
